FILE: rtl/core/tfc_pkg.sv
`timescale 1ns / 1ps

package tfc_pkg;

  localparam int TABLE_ENTRIES_DEF = 32;

  localparam int SLOT_W  = 5;
  localparam int COUNT_W = 64;
  localparam int ADDRS_W = 64;
  localparam int PORTS_W = 32;

  localparam logic [7:0] PROTO_TCP = 8'd6;

  localparam logic [1:0] ST_UNTRACKED = 2'd0;
  localparam logic [1:0] ST_HIT       = 2'd1;
  localparam logic [1:0] ST_INSERTED  = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  typedef struct packed {
    logic        is_ipv4;
    logic [7:0]  l4_proto;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] l4_sport;
    logic [15:0] l4_dport;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [SLOT_W-1:0]  slot;
    logic [COUNT_W-1:0] packet_count;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       load_key;
    logic       clr_idx;
    logic       inc_idx;
    logic       rd;
    logic       wr_hit;
    logic       wr_ins;
    logic       emit;
    logic [1:0] status;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_tcp;
    logic match;
    logic scan_done;
    logic full;
  } dp_status_t;

endpackage

FILE: rtl/core/tfc_ctrl.sv
`timescale 1ns / 1ps

module tfc_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  tfc_pkg::dp_status_t dp_st,
  output tfc_pkg::ctrl_cmd_t  cmd,
  output logic                busy
);
  import tfc_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_CMP  = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  assign busy = (state_r != S_IDLE);

  always_comb begin
    cmd       = '0;
    cmd.status = ST_UNTRACKED;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          if (dp_st.is_tcp) begin
            cmd.load_key = 1'b1;
            cmd.clr_idx  = 1'b1;
            state_nxt    = S_SCAN;
          end else begin
            cmd.emit   = 1'b1;
            cmd.status = ST_UNTRACKED;
          end
        end
      end
      S_SCAN: begin
        if (dp_st.scan_done) begin
          cmd.emit = 1'b1;
          if (dp_st.full) begin
            cmd.status = ST_FULL;
          end else begin
            cmd.status = ST_INSERTED;
            cmd.wr_ins = 1'b1;
          end
          state_nxt = S_IDLE;
        end else begin
          cmd.rd    = 1'b1;
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        if (dp_st.match) begin
          cmd.wr_hit = 1'b1;
          cmd.emit   = 1'b1;
          cmd.status = ST_HIT;
          state_nxt  = S_IDLE;
        end else begin
          cmd.inc_idx = 1'b1;
          state_nxt   = S_SCAN;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: rtl/core/tfc_dp.sv
`timescale 1ns / 1ps

module tfc_dp #(
  parameter int TABLE_ENTRIES = tfc_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  tfc_pkg::in_item_t   in_data,
  input  tfc_pkg::ctrl_cmd_t  cmd,
  output tfc_pkg::dp_status_t dp_st,
  output logic                out_valid,
  output tfc_pkg::out_item_t  out_data
);
  import tfc_pkg::*;

  localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CW = $clog2(TABLE_ENTRIES + 1);
  localparam int KEY_W = ADDRS_W + PORTS_W;
  localparam logic [CW-1:0] FULL_CNT = CW'(TABLE_ENTRIES);

  // Flow keys and counters. Slots fill from zero upward and are never freed,
  // so the occupied slots are always those below the fill count.
  logic [KEY_W-1:0]   key_mem [TABLE_ENTRIES];
  logic [COUNT_W-1:0] cnt_mem [TABLE_ENTRIES];

  logic [KEY_W-1:0]   key_r;
  logic [KEY_W-1:0]   rd_key_r;
  logic [COUNT_W-1:0] rd_cnt_r;
  logic [CW-1:0]      idx_r;
  logic [CW-1:0]      fill_r;
  logic               out_valid_r;
  out_item_t          out_data_r;
  out_item_t          out_data_nxt;
  logic [COUNT_W-1:0] cnt_inc;
  logic [IW-1:0]      addr;

  assign addr    = idx_r[IW-1:0];
  assign cnt_inc = rd_cnt_r + COUNT_W'(1);

  assign dp_st.is_tcp    = in_data.is_ipv4 && (in_data.l4_proto == PROTO_TCP);
  assign dp_st.match     = (rd_key_r == key_r);
  assign dp_st.scan_done = (idx_r == fill_r);
  assign dp_st.full      = (fill_r == FULL_CNT);

  always_comb begin
    out_data_nxt        = '0;
    out_data_nxt.status = cmd.status;
    if (cmd.wr_hit) begin
      out_data_nxt.slot         = SLOT_W'(idx_r);
      out_data_nxt.packet_count = cnt_inc;
    end else if (cmd.wr_ins) begin
      out_data_nxt.slot         = SLOT_W'(idx_r);
      out_data_nxt.packet_count = COUNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit;
      if (cmd.clr_idx) begin
        idx_r <= '0;
      end else if (cmd.inc_idx) begin
        idx_r <= idx_r + CW'(1);
      end
      if (cmd.wr_ins) begin
        fill_r <= fill_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_key) begin
      key_r <= {in_data.src_addr, in_data.dst_addr, in_data.l4_sport, in_data.l4_dport};
    end
    if (cmd.emit) begin
      out_data_r <= out_data_nxt;
    end
  end

  // Table memory: one registered read port, one write port.
  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      rd_key_r <= key_mem[addr];
      rd_cnt_r <= cnt_mem[addr];
    end
    if (cmd.wr_ins) begin
      key_mem[addr] <= key_r;
      cnt_mem[addr] <= COUNT_W'(1);
    end else if (cmd.wr_hit) begin
      cnt_mem[addr] <= cnt_inc;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: rtl/core/tcp_flow_counter_table.sv
`timescale 1ns / 1ps

// Channel   Ports                       Transfer
// input     start, busy, in_data        at a clock edge with start high and busy low
// result    out_valid, out_data         one cycle with out_valid high, always taken
//
// A non-TCP packet is answered without a scan and busy stays low. A TCP packet
// scans the occupied slots one at a time through the table memory's single read
// port, reading each slot and then comparing it; the scan stops at a hit, or at
// the fill count for a miss or a full table.
// Synchronous reset empties the table by clearing the fill count; no clearing
// pass is needed. The receiver cannot stall, so results never back up.

module tcp_flow_counter_table #(
  parameter int TABLE_ENTRIES = tfc_pkg::TABLE_ENTRIES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  tfc_pkg::in_item_t  in_data,
  output logic               out_valid,
  output tfc_pkg::out_item_t out_data
);
  import tfc_pkg::*;

  // The controller sequences the scan; the datapath holds the key, the
  // table memory, the scan index and the fill count.
  ctrl_cmd_t  cmd;
  dp_status_t dp_st;

  tfc_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .dp_st (dp_st),
    .cmd   (cmd),
    .busy  (busy)
  );

  // Inserted flows always land in the lowest free slot, which is exactly the
  // fill count, so the scan ends at the fill count and the insert writes there.
  tfc_dp #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .dp_st     (dp_st),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
